// File: hw/rtl/assert_macros.svh
// assertion helpers used by the rtl controller
// each check is sampled on the rising clock edge and is off while reset is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// File: hw/rtl/htdar_pkg.sv
`default_nettype none

package htdar_pkg;

  // table geometry and score constants
  localparam int INDEX_BITS  = 12;
  localparam int SLOT_COUNT  = 1 << INDEX_BITS;
  localparam int MATE_SCORE  = 32000;
  localparam int MAX_PLY     = 128;
  localparam int SCORE_LIMIT = MATE_SCORE - MAX_PLY;

  // request codes
  localparam logic [1:0] REQ_SAVE       = 2'd0;
  localparam logic [1:0] REQ_PROBE      = 2'd1;
  localparam logic [1:0] REQ_NEW_SEARCH = 2'd2;
  localparam logic [1:0] REQ_CLEAR      = 2'd3;

  // configuration port
  localparam int   CFG_ADDR_W    = 3;
  localparam int   CFG_DATA_W    = 32;
  localparam logic CFG_IDX_EXACT = 1'b0;

  typedef logic [INDEX_BITS-1:0] slot_idx_t;

  localparam slot_idx_t SLOT_LAST = '1;

  // one table slot
  typedef struct packed {
    logic [63:0]        key;
    logic signed [15:0] score;
    logic [7:0]         depth;
    logic [1:0]         flag;
    logic [15:0]        move;
    logic [7:0]         age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic      accept;
    logic      commit;
    logic      sweep_we;
    slot_idx_t sweep_addr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_clear;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/htdar_ram.sv
`default_nettype none

module htdar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/htdar_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module htdar_ctrl
  import htdar_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output logic      in_stall,
  output logic      out_valid,
  output cmd_t      cmd
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0] state_r, state_nxt;
  slot_idx_t  sweep_cnt_r, sweep_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       commit;
  logic       out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == ST_DECIDE) && out_free;
  assign out_valid = out_valid_r;

  // commands to the datapath
  always_comb begin
    cmd.accept     = accept;
    cmd.commit     = commit;
    cmd.sweep_we   = (state_r == ST_CLEAR);
    cmd.sweep_addr = sweep_cnt_r;
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    sweep_cnt_nxt = sweep_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        if (sweep_cnt_r == SLOT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (commit) begin
          if (sts.req_clear) begin
            state_nxt     = ST_CLEAR;
            sweep_cnt_nxt = '0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt     = ST_CLEAR;
        sweep_cnt_nxt = '0;
      end
    endcase
  end

  // result slot occupancy
  always_comb begin
    priority if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state registers; reset starts with a sweep of the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_IMPLIES(a_commit_room, clk, rst_n, commit, !out_valid_r || !out_stall, "commit with full result slot")
  `ASSERT_NEXT(a_accept_decide, clk, rst_n, accept, state_r == ST_DECIDE, "accept not followed by decide")
  `ASSERT_NEXT(a_sweep_runs, clk, rst_n, (state_r == ST_CLEAR) && (sweep_cnt_r != SLOT_LAST), state_r == ST_CLEAR, "sweep left early")
  `ASSERT_NEXT(a_clear_start, clk, rst_n, commit && sts.req_clear, (state_r == ST_CLEAR) && (sweep_cnt_r == '0), "clear did not start sweep")

endmodule

`default_nettype wire

// File: hw/rtl/htdar_dp.sv
`default_nettype none

module htdar_dp
  import htdar_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic [1:0]         exact_code,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [63:0]        in_key,
  input  wire logic signed [15:0] in_score,
  input  wire logic [7:0]         in_depth,
  input  wire logic [1:0]         in_bound_flag,
  input  wire logic [15:0]        in_best_move,
  input  wire logic [7:0]         in_ply,
  output logic                    ram_we,
  output slot_idx_t               ram_waddr,
  output logic [ENTRY_W-1:0]      ram_wdata,
  output logic                    ram_re,
  output slot_idx_t               ram_raddr,
  input  wire logic [ENTRY_W-1:0] ram_rdata,
  output logic                    out_hit,
  output logic                    out_stored,
  output logic signed [15:0]      out_entry_score,
  output logic [7:0]              out_entry_depth,
  output logic [1:0]              out_entry_flag,
  output logic [15:0]             out_entry_move
);

  localparam logic signed [17:0] LIM_P  = 18'(SCORE_LIMIT);
  localparam logic signed [17:0] LIM_N  = 18'(-SCORE_LIMIT);
  localparam logic signed [17:0] SAT_HI = 18'sd32767;
  localparam logic signed [17:0] SAT_LO = -18'sd32768;

  // latched request
  logic [1:0]         req_r;
  logic [63:0]        key_r;
  logic signed [15:0] score_r;
  logic [7:0]         depth_r;
  logic [1:0]         flag_r;
  logic [15:0]        move_r;
  logic [7:0]         age_r, age_nxt;

  // result registers
  logic               hit_r, stored_r;
  logic signed [15:0] e_score_r;
  logic [7:0]         e_depth_r;
  logic [1:0]         e_flag_r;
  logic [15:0]        e_move_r;

  logic signed [17:0] sc_ext, ply_ext, sc_sum;
  logic signed [15:0] sc_adj;
  entry_t             rd;
  entry_t             wr;
  logic               new_exact, old_exact, bonus;
  logic signed [8:0]  gap;
  logic signed [10:0] eff;
  logic               save_ok, probe_hit;

  // mate score push and saturation, done on the incoming item
  always_comb begin
    sc_ext  = $signed({{2{in_score[15]}}, in_score});
    ply_ext = $signed({10'b0, in_ply});
    priority if (sc_ext > LIM_P) begin
      sc_sum = sc_ext + ply_ext;
    end else if (sc_ext < LIM_N) begin
      sc_sum = sc_ext - ply_ext;
    end else begin
      sc_sum = sc_ext;
    end
    priority if (sc_sum > SAT_HI) begin
      sc_adj = 16'sh7FFF;
    end else if (sc_sum < SAT_LO) begin
      sc_adj = 16'sh8000;
    end else begin
      sc_adj = sc_sum[15:0];
    end
  end

  // capture the request on transfer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r   <= in_req_type;
      key_r   <= in_key;
      score_r <= sc_adj;
      depth_r <= in_depth;
      flag_r  <= in_bound_flag;
      move_r  <= in_best_move;
    end
  end

  assign ram_re    = cmd.accept;
  assign ram_raddr = in_key[INDEX_BITS-1:0];
  assign rd        = entry_t'(ram_rdata);
  assign sts.req_clear = (req_r == REQ_CLEAR);

  // replacement decision on the slot read back
  always_comb begin
    new_exact = (flag_r == exact_code);
    old_exact = (rd.flag == exact_code);
    bonus     = !new_exact && old_exact;
    gap       = $signed({1'b0, age_r}) - $signed({1'b0, rd.age});
    eff       = $signed({3'b000, rd.depth}) - $signed({gap[8], gap, 1'b0})
                + $signed({10'b0, bonus});
    save_ok   = (rd.key == 64'd0) || (eff <= $signed({3'b000, depth_r}))
                || (new_exact && (rd.age < age_r));
    probe_hit = (rd.key == key_r);
  end

  // new slot contents
  always_comb begin
    wr.key   = key_r;
    wr.score = score_r;
    wr.depth = depth_r;
    wr.flag  = flag_r;
    wr.move  = move_r;
    wr.age   = age_r;
  end

  // table write: sweep or save
  always_comb begin
    if (cmd.sweep_we) begin
      ram_we    = 1'b1;
      ram_waddr = cmd.sweep_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd.commit && (req_r == REQ_SAVE) && save_ok;
      ram_waddr = key_r[INDEX_BITS-1:0];
      ram_wdata = wr;
    end
  end

  // search age
  always_comb begin
    age_nxt = age_r;
    if (cmd.commit) begin
      unique case (req_r)
        REQ_NEW_SEARCH: age_nxt = age_r + 8'd1;
        REQ_CLEAR:      age_nxt = 8'd0;
        default:        age_nxt = age_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r <= 8'd0;
    end else begin
      age_r <= age_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_r    <= (req_r == REQ_PROBE) && probe_hit;
      stored_r <= (req_r == REQ_SAVE) && save_ok;
      if ((req_r == REQ_PROBE) && probe_hit) begin
        e_score_r <= rd.score;
        e_depth_r <= rd.depth;
        e_flag_r  <= rd.flag;
        e_move_r  <= rd.move;
      end else begin
        e_score_r <= '0;
        e_depth_r <= '0;
        e_flag_r  <= '0;
        e_move_r  <= '0;
      end
    end
  end

  assign out_hit         = hit_r;
  assign out_stored      = stored_r;
  assign out_entry_score = e_score_r;
  assign out_entry_depth = e_depth_r;
  assign out_entry_flag  = e_flag_r;
  assign out_entry_move  = e_move_r;

endmodule

`default_nettype wire

// File: hw/rtl/hash_table_depth_age_replace.sv
`default_nettype none
// Direct-mapped search-result table with depth/age replacement.
// Input channel (in_valid / in_stall): one request per transfer: save, probe,
// new search (age step) or clear, with key, score, depth, flag, move and ply.
// Result channel (out_valid / out_stall): exactly one result per request,
// hit and stored flags plus the stored fields on a probe hit, else zeros.
// Sequence: a request is taken while idle and its slot is read from the table
// memory; the decision and write-back follow in the decision state, which waits
// while a stalled result fills the result register. Save, probe and new search
// each run this read-modify-write of the single table memory. The result is
// valid the cycle after the decision. Clear adds a sweep of all 4096 slots, one
// slot per cycle, during which in_stall is high.
// Reset: synchronous, active low; after reset the same sweep of all 4096 slots
// empties the table before the first request is taken; the age and the
// exact_code register read zero. Register writes are taken at any time.
// A stalled result holds; one further request may be taken meanwhile and
// waits in its decision cycle until the result register frees up.
// Register 0 at byte address 0: exact_code, bits 1:0.

module hash_table_depth_age_replace
  import htdar_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_req_type,
  input  wire logic [63:0]           in_key,
  input  wire logic signed [15:0]    in_score,
  input  wire logic [7:0]            in_depth,
  input  wire logic [1:0]            in_bound_flag,
  input  wire logic [15:0]           in_best_move,
  input  wire logic [7:0]            in_ply,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_hit,
  output logic                       out_stored,
  output logic signed [15:0]         out_entry_score,
  output logic [7:0]                 out_entry_depth,
  output logic [1:0]                 out_entry_flag,
  output logic [15:0]                out_entry_move,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  cmd_t               cmd;
  sts_t               sts;
  logic [1:0]         exact_code_r;
  logic               ram_we, ram_re;
  slot_idx_t          ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic               reg_sel;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1] == CFG_IDX_EXACT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exact_code_r <= 2'd0;
    end else if (psel && penable && pwrite && reg_sel) begin
      exact_code_r <= pwdata[1:0];
    end
  end

  assign prdata = reg_sel ? {{(CFG_DATA_W-2){1'b0}}, exact_code_r} : '0;

  htdar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  htdar_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .exact_code      (exact_code_r),
    .in_req_type     (in_req_type),
    .in_key          (in_key),
    .in_score        (in_score),
    .in_depth        (in_depth),
    .in_bound_flag   (in_bound_flag),
    .in_best_move    (in_best_move),
    .in_ply          (in_ply),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .out_hit         (out_hit),
    .out_stored      (out_stored),
    .out_entry_score (out_entry_score),
    .out_entry_depth (out_entry_depth),
    .out_entry_flag  (out_entry_flag),
    .out_entry_move  (out_entry_move)
  );

  htdar_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
